// ===== rtl/dq_pkg.sv =====
// Shared constants, codes and transfer types for the double-ended queue.
package dq_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = CNT_W + 1;
  localparam int WORD_W = 32;
  localparam int OCC_W  = 5;

  localparam logic [1:0] OP_PUSH_FRONT = 2'd0;
  localparam logic [1:0] OP_PUSH_BACK  = 2'd1;
  localparam logic [1:0] OP_POP_FRONT  = 2'd2;
  localparam logic [1:0] OP_POP_BACK   = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;

  typedef enum logic {
    S_IDLE,
    S_BUSY
  } state_t;

  typedef struct packed {
    logic [1:0]               opcode;
    logic signed [WORD_W-1:0] push_value;
  } dq_req_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] pop_value;
    logic [1:0]               status;
    logic [OCC_W-1:0]         occupancy;
    logic                     is_empty;
  } dq_rsp_t;

  // Memory access and outcome of one operation, from the pointer unit.
  typedef struct packed {
    logic [1:0]       status;
    logic [CNT_W-1:0] count;
    logic             rd_en;
    logic             wr_en;
    logic [IDX_W-1:0] addr;
  } dq_acc_t;

endpackage

// ===== rtl/dq_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/dq_ptr.sv =====
// Front index and word count of the ring, with the slot address of each operation.
module dq_ptr import dq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       op_valid,
  input  logic [1:0] opcode,
  output dq_acc_t    acc
);

  logic [IDX_W-1:0] front;
  logic [IDX_W-1:0] front_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [IDX_W-1:0] front_dec;
  logic [IDX_W-1:0] front_inc;
  logic [SUM_W-1:0] back_sum;
  logic [SUM_W-1:0] last_sum;
  logic [IDX_W-1:0] back_idx;
  logic [IDX_W-1:0] last_idx;
  logic             full;
  logic             empty;
  logic             rd;
  logic             wr;

  always_comb begin
    full      = (count == CNT_W'(DEPTH));
    empty     = (count == '0);
    front_dec = (front == '0) ? IDX_W'(DEPTH - 1) : front - 1'b1;
    front_inc = (front == IDX_W'(DEPTH - 1)) ? '0 : front + 1'b1;
    back_sum  = SUM_W'(front) + SUM_W'(count);
    last_sum  = back_sum - 1'b1;
    // Sums stay below twice the depth, so one subtract wraps them.
    back_idx  = (back_sum >= SUM_W'(DEPTH)) ? IDX_W'(back_sum - SUM_W'(DEPTH))
                                            : IDX_W'(back_sum);
    last_idx  = (last_sum >= SUM_W'(DEPTH)) ? IDX_W'(last_sum - SUM_W'(DEPTH))
                                            : IDX_W'(last_sum);
  end

  always_comb begin
    front_next = front;
    count_next = count;
    acc.status = ST_OK;
    rd         = 1'b0;
    wr         = 1'b0;
    acc.addr   = front;
    case (opcode)
      OP_PUSH_FRONT: begin
        if (full) begin
          acc.status = ST_OVERFLOW;
        end else begin
          front_next = front_dec;
          acc.addr   = front_dec;
          wr         = 1'b1;
          count_next = count + 1'b1;
        end
      end
      OP_PUSH_BACK: begin
        if (full) begin
          acc.status = ST_OVERFLOW;
        end else begin
          acc.addr   = back_idx;
          wr         = 1'b1;
          count_next = count + 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          acc.status = ST_UNDERFLOW;
        end else begin
          acc.addr   = front;
          front_next = front_inc;
          rd         = 1'b1;
          count_next = count - 1'b1;
        end
      end
      default: begin
        if (empty) begin
          acc.status = ST_UNDERFLOW;
        end else begin
          acc.addr   = last_idx;
          rd         = 1'b1;
          count_next = count - 1'b1;
        end
      end
    endcase
    acc.count = count_next;
    acc.rd_en = rd & op_valid;
    acc.wr_en = wr & op_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      count <= '0;
    end else if (op_valid) begin
      front <= front_next;
      count <= count_next;
    end
  end

endmodule

// ===== rtl/double_ended_queue_top.sv =====
// Top level of the double-ended queue: handshake control, slot RAM and result register.
// A result enters the result register from the busy state that follows the acceptance of its operation.
// The block takes no new operation while busy, as it waits on the registered read of the slot RAM.
// A stalled result register holds the block in its busy state until the result is taken.
// Reset (synchronous, active high) empties the queue: front index and count go to zero.
// The slot RAM is not cleared; a pop only ever reads a slot that a push has written.
module double_ended_queue_top import dq_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  output logic    req_stall,
  input  dq_req_t req,
  output logic    rsp_valid,
  input  logic    rsp_stall,
  output dq_rsp_t rsp
);

  state_t            state;
  state_t            state_next;
  logic              req_take;
  logic              rsp_load;
  dq_acc_t           acc;
  logic [WORD_W-1:0] rd_data;

  // Outcome of the operation in flight, kept until the result register frees up.
  logic [1:0]        pend_status;
  logic [CNT_W-1:0]  pend_count;
  logic              pend_pop;

  assign req_take = req_valid && !req_stall;

  // The pointer unit sees the opcode and moves its registers on the transfer cycle.
  dq_ptr u_ptr (
    .clk      (clk),
    .rst      (rst),
    .op_valid (req_take),
    .opcode   (req.opcode),
    .acc      (acc)
  );

  // Pushes write their word in the transfer cycle; pops read it and the data
  // appears in the next cycle, while the controller is busy and takes no new item,
  // so a read never meets a write to the same slot.
  dq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (acc.wr_en),
    .wr_addr (acc.addr),
    .wr_data (req.push_value),
    .rd_en   (acc.rd_en),
    .rd_addr (acc.addr),
    .rd_data (rd_data)
  );

  // Next state of the controller.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_take) begin
          state_next = S_BUSY;
        end
      end
      S_BUSY: begin
        if (rsp_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Controller outputs: new transfers only while idle, and the result moves
  // into the result register once it is empty or being emptied this cycle.
  always_comb begin
    req_stall = 1'b1;
    rsp_load  = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_stall = 1'b0;
      end
      S_BUSY: begin
        rsp_load = !rsp_valid || !rsp_stall;
      end
      default: begin
        req_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      pend_status <= acc.status;
      pend_count  <= acc.count;
      pend_pop    <= acc.rd_en;
    end
  end

  // Result register: the block takes its next transfer while a result waits here.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.pop_value <= pend_pop ? $signed(rd_data) : '0;
      rsp.status    <= pend_status;
      rsp.occupancy <= OCC_W'(pend_count);
      rsp.is_empty  <= (pend_count == '0);
    end
  end

`ifndef SYNTH
  // A rejected operation never hands out a word.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == ST_UNDERFLOW || rsp.status == ST_OVERFLOW)
      |-> rsp.pop_value == '0)
    else $error("rejected operation returned a nonzero word");

  // A transfer made while the output is free always leads to a result load in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    req_take && (!rsp_valid || !rsp_stall) |=> rsp_load)
    else $error("accepted operation did not reach the result register");

  // An underflow can only be reported on an empty queue.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_UNDERFLOW |-> rsp.is_empty)
    else $error("underflow reported on a non-empty queue");
`endif

endmodule
